// ===== hw/rtl/asch_pkg.sv =====
// Shared types and constants for the size-class histogram block.
// Depends on nothing; imported by the interfaces and every module.
package asch_pkg;

  localparam int NUM_BINS   = 151;
  localparam int BIN_W      = 8;
  localparam int SIZE_W     = 32;
  localparam int DATA_W     = 32;
  localparam int TIMES_W    = 64;
  localparam int CMD_W      = 2;
  localparam int FIFO_DEPTH = 2;

  // size-class layout
  localparam int SMALL_MAX         = 4;
  localparam int LOG2_BIN_SHIFT    = 3;
  localparam int LIN_SHIFT         = 2;
  localparam int COMPACT_LIN_MAX   = 512;
  localparam int COMPACT_LIN_BINS  = 128;
  localparam int COMPACT_BIN_SHIFT = 10;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC      = 2'd0,
    CMD_FREE       = 2'd1,
    CMD_READ_BIN   = 2'd2,
    CMD_READ_TOTAL = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [SIZE_W-1:0] size;
    logic [BIN_W-1:0]  bin;
  } item_t;

  typedef struct packed {
    logic [TIMES_W-1:0] times;
    logic [DATA_W-1:0]  live_count;
    logic [DATA_W-1:0]  live_bytes;
    logic [DATA_W-1:0]  peak_count;
    logic [DATA_W-1:0]  peak_bytes;
  } rec_t;

endpackage

// ===== hw/rtl/asch_in_if.sv =====
// Event channel: valid/ready handshake carrying command, size and bin select.
// Depends on asch_pkg.
interface asch_in_if;
  import asch_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SIZE_W-1:0] block_size;
  logic [BIN_W-1:0]  bin_select;

  modport source (output valid, command, block_size, bin_select, input ready);
  modport sink   (input valid, command, block_size, bin_select, output ready);
endinterface

// ===== hw/rtl/asch_out_if.sv =====
// Record channel: valid/ready handshake carrying one bin or totals record.
// Depends on asch_pkg.
interface asch_out_if;
  import asch_pkg::*;

  logic               valid;
  logic               ready;
  logic [BIN_W-1:0]   bin_index;
  logic [TIMES_W-1:0] alloc_times;
  logic [DATA_W-1:0]  current_count;
  logic [DATA_W-1:0]  current_bytes;
  logic [DATA_W-1:0]  peak_count;
  logic [DATA_W-1:0]  peak_bytes;

  modport source (output valid, bin_index, alloc_times, current_count, current_bytes,
                  peak_count, peak_bytes, input ready);
  modport sink   (input valid, bin_index, alloc_times, current_count, current_bytes,
                  peak_count, peak_bytes, output ready);
endinterface

// ===== hw/rtl/asch_fifo.sv =====
// Short queue between the classifying front end and the update back end.
// Depends on asch_pkg (item_t, FIFO_DEPTH).
module asch_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  asch_pkg::item_t push_item_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output asch_pkg::item_t pop_item_o,
  input  logic            pop_ready_i
);
  import asch_pkg::*;

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int LVL_W = $clog2(FIFO_DEPTH + 1);

  item_t            slot_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [LVL_W-1:0] level_q;
  logic             push, pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(FIFO_DEPTH - 1)) return '0;
    return p + PTR_W'(1);
  endfunction

  assign push_ready_o = (level_q != LVL_W'(FIFO_DEPTH));
  assign pop_valid_o  = (level_q != '0);
  assign pop_item_o   = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= ptr_inc(wr_ptr_q);
      if (pop)  rd_ptr_q <= ptr_inc(rd_ptr_q);
      if (push && !pop)      level_q <= level_q + LVL_W'(1);
      else if (pop && !push) level_q <= level_q - LVL_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_item_i;
  end

endmodule

// ===== hw/rtl/asch_front.sv =====
// Front end: accepts event transactions and maps the block size to a bin.
// Depends on asch_pkg and asch_in_if.
module asch_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            compact_mode_i,
  asch_in_if.sink         evt_i,
  output logic            q_valid_o,
  output asch_pkg::item_t q_item_o,
  input  logic            q_ready_i
);
  import asch_pkg::*;

  logic  valid_q;
  item_t item_q, item_d;
  logic  accept;
  cmd_e  cmd;

  // position of the highest set bit, plus one
  function automatic logic [5:0] bit_len(input logic [SIZE_W-1:0] v);
    logic [5:0] len;
    len = '0;
    for (int i = 0; i < SIZE_W; i++) begin
      if (v[i]) len = 6'(i + 1);
    end
    return len;
  endfunction

  function automatic logic [BIN_W-1:0] size_to_bin(input logic [SIZE_W-1:0] size,
                                                   input logic            compact);
    logic [SIZE_W-1:0] v;
    logic [BIN_W:0]    idx;
    v = size - SIZE_W'(1);
    if (size <= SIZE_W'(SMALL_MAX)) begin
      idx = '0;
    end else if (!compact) begin
      idx = (BIN_W+1)'(1) + (BIN_W+1)'(bit_len(v >> LOG2_BIN_SHIFT));
    end else if (size <= SIZE_W'(COMPACT_LIN_MAX)) begin
      idx = (BIN_W+1)'(v >> LIN_SHIFT);
    end else begin
      idx = (BIN_W+1)'(COMPACT_LIN_BINS) + (BIN_W+1)'(bit_len(v >> COMPACT_BIN_SHIFT));
    end
    if (idx > (BIN_W+1)'(NUM_BINS - 1)) idx = (BIN_W+1)'(NUM_BINS - 1);
    return idx[BIN_W-1:0];
  endfunction

  assign cmd         = cmd_e'(evt_i.command);
  assign evt_i.ready = !valid_q || q_ready_i;
  assign accept      = evt_i.valid && evt_i.ready;

  always_comb begin
    item_d.cmd  = cmd;
    item_d.size = evt_i.block_size;
    unique case (cmd)
      CMD_ALLOC, CMD_FREE: item_d.bin = size_to_bin(evt_i.block_size, compact_mode_i);
      CMD_READ_BIN:        item_d.bin = evt_i.bin_select;
      CMD_READ_TOTAL:      item_d.bin = '0;
      default:             item_d.bin = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (evt_i.ready) begin
      valid_q <= evt_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= item_d;
  end

  assign q_valid_o = valid_q;
  assign q_item_o  = item_q;

endmodule

// ===== hw/rtl/asch_back.sv =====
// Back end: bin record RAM read-modify-write with forwarding, totals, result register.
// Depends on asch_pkg and asch_out_if.
module asch_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            q_valid_i,
  input  asch_pkg::item_t q_item_i,
  output logic            q_ready_o,
  asch_out_if.source      rec_o
);
  import asch_pkg::*;

  rec_t               mem [NUM_BINS];
  logic [NUM_BINS-1:0] vld_q;

  logic             e_valid_q;
  item_t            e_item_q;
  logic             fwd_hit_q;
  rec_t             fwd_rec_q;
  rec_t             rd_rec_q;
  logic             rd_vld_q;
  rec_t             tot_q, tot_d;
  logic             out_valid_q;
  logic [BIN_W-1:0] out_bin_q;
  rec_t             out_rec_q;

  rec_t             cur_rec, new_rec, res_rec;
  logic [BIN_W-1:0] res_bin, rd_addr;
  logic             e_fire, e_ready, pop, e_wr, head_rd;

  function automatic logic bin_ok(input logic [BIN_W-1:0] b);
    return {1'b0, b} < (BIN_W+1)'(NUM_BINS);
  endfunction

  assign head_rd = (q_item_i.cmd == CMD_ALLOC) || (q_item_i.cmd == CMD_FREE) ||
                   ((q_item_i.cmd == CMD_READ_BIN) && bin_ok(q_item_i.bin));
  assign rd_addr = head_rd ? q_item_i.bin : '0;
  assign e_wr    = (e_item_q.cmd == CMD_ALLOC) || (e_item_q.cmd == CMD_FREE);
  assign e_fire  = e_valid_q && (!out_valid_q || rec_o.ready);
  assign e_ready = !e_valid_q || e_fire;
  assign pop     = q_valid_i && e_ready;
  assign q_ready_o = e_ready;

  // record as seen by the item in the execute stage
  assign cur_rec = fwd_hit_q ? fwd_rec_q : (rd_vld_q ? rd_rec_q : '0);

  always_comb begin
    new_rec = cur_rec;
    tot_d   = tot_q;
    res_rec = '0;
    res_bin = e_item_q.bin;
    unique case (e_item_q.cmd)
      CMD_ALLOC: begin
        new_rec.times      = cur_rec.times + TIMES_W'(1);
        new_rec.live_count = cur_rec.live_count + DATA_W'(1);
        new_rec.live_bytes = cur_rec.live_bytes + e_item_q.size;
        if (new_rec.peak_count < new_rec.live_count) new_rec.peak_count = new_rec.live_count;
        if (new_rec.peak_bytes < new_rec.live_bytes) new_rec.peak_bytes = new_rec.live_bytes;
        tot_d.times      = tot_q.times + TIMES_W'(1);
        tot_d.live_count = tot_q.live_count + DATA_W'(1);
        tot_d.live_bytes = tot_q.live_bytes + e_item_q.size;
        if (tot_d.peak_count < tot_d.live_count) tot_d.peak_count = tot_d.live_count;
        if (tot_d.peak_bytes < tot_d.live_bytes) tot_d.peak_bytes = tot_d.live_bytes;
        res_rec = new_rec;
      end
      CMD_FREE: begin
        new_rec.live_count = cur_rec.live_count - DATA_W'(1);
        new_rec.live_bytes = cur_rec.live_bytes - e_item_q.size;
        tot_d.live_count   = tot_q.live_count - DATA_W'(1);
        tot_d.live_bytes   = tot_q.live_bytes - e_item_q.size;
        res_rec = new_rec;
      end
      CMD_READ_BIN: begin
        res_rec = bin_ok(e_item_q.bin) ? cur_rec : '0;
      end
      CMD_READ_TOTAL: begin
        res_rec = tot_q;
        res_bin = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q   <= 1'b0;
      fwd_hit_q   <= 1'b0;
      rd_vld_q    <= 1'b0;
      vld_q       <= '0;
      tot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (e_ready) begin
        e_valid_q <= q_valid_i;
        fwd_hit_q <= pop && head_rd && e_fire && e_wr && (e_item_q.bin == q_item_i.bin);
        rd_vld_q  <= pop && head_rd && vld_q[rd_addr];
      end
      if (e_fire && e_wr) vld_q[e_item_q.bin] <= 1'b1;
      if (e_fire) tot_q <= tot_d;
      if (e_fire)           out_valid_q <= 1'b1;
      else if (rec_o.ready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      e_item_q  <= q_item_i;
      fwd_rec_q <= new_rec;
    end
    if (e_fire) begin
      out_bin_q <= res_bin;
      out_rec_q <= res_rec;
    end
  end

  // record RAM: one read, one write port, registered read
  always_ff @(posedge clk_i) begin
    if (pop && head_rd) rd_rec_q <= mem[rd_addr];
    if (e_fire && e_wr) mem[e_item_q.bin] <= new_rec;
  end

  assign rec_o.valid         = out_valid_q;
  assign rec_o.bin_index     = out_bin_q;
  assign rec_o.alloc_times   = out_rec_q.times;
  assign rec_o.current_count = out_rec_q.live_count;
  assign rec_o.current_bytes = out_rec_q.live_bytes;
  assign rec_o.peak_count    = out_rec_q.peak_count;
  assign rec_o.peak_bytes    = out_rec_q.peak_bytes;

  a_fwd_only_with_e: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fwd_hit_q |-> e_valid_q)
    else $error("forward hit without an item in execute");

  a_pop_fills_e: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> e_valid_q)
    else $error("popped transaction lost before execute");

  a_stall_holds_e: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_valid_q && out_valid_q && !rec_o.ready) |=> (e_valid_q && $stable(e_item_q)))
    else $error("execute stage moved while result stalled");

  a_wr_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_fire && e_wr) |-> ({1'b0, e_item_q.bin} < (BIN_W+1)'(NUM_BINS)))
    else $error("record write beyond last bin");

  a_alloc_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (e_fire && (e_item_q.cmd == CMD_ALLOC)) |->
      ((new_rec.peak_count >= new_rec.live_count) &&
       (tot_d.peak_count >= tot_d.live_count)))
    else $error("peak below live count after allocation");

endmodule

// ===== hw/rtl/alloc_size_class_histogram.sv =====
// Allocation size-class histogram, top level.
// Depends on asch_pkg, asch_in_if, asch_out_if, asch_front, asch_fifo, asch_back.
//
// Usage:
//   evt_i carries one event per transaction: allocate, free, read one bin or
//   read totals, with a 32-bit block size and a bin select for bin reads.
//   rec_o returns exactly one record per event, in event order: the bin that
//   was updated or read (0 for totals) and its five counters after the update.
//   cfg_we_i/cfg_data_i write the compact_mode bit (0 log2 bins, 1 linear
//   4-byte bins up to 512 then log2); write it only while the block is idle.
// Timing:
//   One event per cycle sustained while rec_o keeps ready high. After the
//   accepting edge a record passes the classify register, queue, RAM read
//   stage and result register. Same-bin updates on consecutive cycles are
//   covered by forwarding from the RAM write port into the read stage.
// Reset:
//   All counters read as zero right after reset; per-bin valid flops mask
//   unwritten RAM entries, so there is no clearing pass.
// Backpressure:
//   When rec_o stalls, the result register holds, the back end and the
//   two-entry queue fill up and evt_i.ready drops; nothing is lost.
module alloc_size_class_histogram (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  asch_in_if.sink     evt_i,
  asch_out_if.source  rec_o
);
  import asch_pkg::*;

  logic  compact_q;
  logic  fq_valid, fq_ready;
  item_t fq_item;
  logic  bq_valid, bq_ready;
  item_t bq_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      compact_q <= 1'b0;
    end else if (cfg_we_i) begin
      compact_q <= cfg_data_i;
    end
  end

  asch_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .compact_mode_i (compact_q),
    .evt_i          (evt_i),
    .q_valid_o      (fq_valid),
    .q_item_o       (fq_item),
    .q_ready_i      (fq_ready)
  );

  asch_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_item_i  (fq_item),
    .push_ready_o (fq_ready),
    .pop_valid_o  (bq_valid),
    .pop_item_o   (bq_item),
    .pop_ready_i  (bq_ready)
  );

  asch_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (bq_valid),
    .q_item_i  (bq_item),
    .q_ready_o (bq_ready),
    .rec_o     (rec_o)
  );

endmodule

// ===== test/tb.sv =====
// Testbench for alloc_size_class_histogram: directed and random allocate, free
// and read events, with random valid/ready idling, checked by a behavioral model.
// Depends on asch_pkg, asch_in_if, asch_out_if and the block under test.
module tb;
  import asch_pkg::*;

  typedef struct {
    logic [BIN_W-1:0] bin;
    rec_t             rec;
  } bin_record_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_data_i;

  asch_in_if  evt_if();
  asch_out_if rec_if();

  alloc_size_class_histogram DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .evt_i      (evt_if),
    .rec_o      (rec_if)
  );

  item_t           event_q[$];
  bin_record_t     pending_records[$];
  logic [SIZE_W-1:0] live_sizes[$];
  rec_t            bin_state[NUM_BINS];
  rec_t            grand_total;
  logic            compact;
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  int unsigned     errors;

  function automatic logic [BIN_W-1:0] size_class(logic [SIZE_W-1:0] sz);
    int unsigned       idx;
    logic [SIZE_W-1:0] rest;
    logic [SIZE_W-1:0] lin;
    if (sz <= SMALL_MAX) return '0;
    if (!compact) begin
      idx  = 1;
      rest = (sz - 1) >> LOG2_BIN_SHIFT;
    end else begin
      if (sz <= COMPACT_LIN_MAX) begin
        lin = (sz - 1) >> LIN_SHIFT;
        return lin[BIN_W-1:0];
      end
      idx  = COMPACT_LIN_BINS;
      rest = (sz - 1) >> COMPACT_BIN_SHIFT;
    end
    while (rest != 0) begin
      rest = rest >> 1;
      idx++;
    end
    if (idx >= NUM_BINS) idx = NUM_BINS - 1;
    return idx[BIN_W-1:0];
  endfunction

  function automatic rec_t after_alloc(rec_t s, logic [SIZE_W-1:0] sz);
    s.times      += 1;
    s.live_count += 1;
    s.live_bytes += sz;
    if (s.peak_count < s.live_count) s.peak_count = s.live_count;
    if (s.peak_bytes < s.live_bytes) s.peak_bytes = s.live_bytes;
    return s;
  endfunction

  function automatic rec_t after_free(rec_t s, logic [SIZE_W-1:0] sz);
    s.live_count -= 1;
    s.live_bytes -= sz;
    return s;
  endfunction

  function automatic void account_event(cmd_e cmd, logic [SIZE_W-1:0] sz,
                                        logic [BIN_W-1:0] sel);
    bin_record_t      r;
    logic [BIN_W-1:0] b;
    r.bin = '0;
    r.rec = '0;
    b     = size_class(sz);
    case (cmd)
      CMD_ALLOC: begin
        grand_total  = after_alloc(grand_total, sz);
        bin_state[b] = after_alloc(bin_state[b], sz);
        r.bin        = b;
        r.rec        = bin_state[b];
      end
      CMD_FREE: begin
        grand_total  = after_free(grand_total, sz);
        bin_state[b] = after_free(bin_state[b], sz);
        r.bin        = b;
        r.rec        = bin_state[b];
      end
      CMD_READ_BIN: begin
        r.bin = sel;
        if (sel < NUM_BINS) r.rec = bin_state[sel];
      end
      default: begin
        r.rec = grand_total;
      end
    endcase
    pending_records.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [TIMES_W-1:0] want,
                                      logic [TIMES_W-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void queue_event(cmd_e cmd, logic [SIZE_W-1:0] sz,
                                      logic [BIN_W-1:0] sel);
    item_t ev;
    ev.cmd  = cmd;
    ev.size = sz;
    ev.bin  = sel;
    event_q.push_back(ev);
  endfunction

  function automatic logic [SIZE_W-1:0] random_size();
    int unsigned k;
    case ($urandom_range(5))
      0:       return $urandom_range(SMALL_MAX);
      1:       return $urandom_range(600);
      2: begin
        k = $urandom_range(31);
        return (32'd1 << k) - 32'd1 + $urandom_range(2);
      end
      3:       return $urandom >> $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  function automatic void queue_random_event();
    item_t       ev;
    int unsigned pick;
    int unsigned idx;
    pick    = $urandom_range(99);
    ev.size = $urandom;
    ev.bin  = ($urandom_range(99) < 85) ? BIN_W'($urandom_range(NUM_BINS - 1))
                                        : BIN_W'($urandom_range(255, NUM_BINS));
    if (pick < 45) begin
      ev.cmd  = CMD_ALLOC;
      ev.size = random_size();
      live_sizes.push_back(ev.size);
    end else if (pick < 70) begin
      ev.cmd = CMD_FREE;
      if (live_sizes.size() != 0 && $urandom_range(99) < 85) begin
        idx     = $urandom_range(live_sizes.size() - 1);
        ev.size = live_sizes[idx];
        live_sizes.delete(idx);
      end else begin
        ev.size = random_size();
      end
    end else if (pick < 85) begin
      ev.cmd = CMD_READ_BIN;
    end else begin
      ev.cmd = CMD_READ_TOTAL;
    end
    event_q.push_back(ev);
  endfunction

  task automatic drain();
    while (event_q.size() != 0 || evt_if.valid) @(negedge clk_i);
    while (pending_records.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_mode(logic v);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    compact = v;
  endtask

  task automatic random_phase(int unsigned n);
    repeat (n) queue_random_event();
    drain();
  endtask

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // event driver; model updated on each accepted transaction
  always @(posedge clk_i) begin : driver
    item_t nxt;
    if (rst_ni) begin
      if (evt_if.valid && evt_if.ready)
        account_event(cmd_e'(evt_if.command), evt_if.block_size, evt_if.bin_select);
      if (!evt_if.valid || evt_if.ready) begin
        if (event_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          nxt = event_q.pop_front();
          evt_if.valid      <= 1'b1;
          evt_if.command    <= nxt.cmd;
          evt_if.block_size <= nxt.size;
          evt_if.bin_select <= nxt.bin;
        end else begin
          evt_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    bin_record_t want;
    if (rst_ni) begin
      if (rec_if.valid && rec_if.ready) begin
        if (pending_records.size() == 0) begin
          $error("unexpected record for bin %0d", rec_if.bin_index);
          errors++;
        end else begin
          want = pending_records.pop_front();
          check_field("bin_index", TIMES_W'(want.bin), TIMES_W'(rec_if.bin_index));
          check_field("alloc_times", want.rec.times, rec_if.alloc_times);
          check_field("current_count", TIMES_W'(want.rec.live_count),
                      TIMES_W'(rec_if.current_count));
          check_field("current_bytes", TIMES_W'(want.rec.live_bytes),
                      TIMES_W'(rec_if.current_bytes));
          check_field("peak_count", TIMES_W'(want.rec.peak_count),
                      TIMES_W'(rec_if.peak_count));
          check_field("peak_bytes", TIMES_W'(want.rec.peak_bytes),
                      TIMES_W'(rec_if.peak_bytes));
        end
      end
      rec_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    errors            = 0;
    compact           = 1'b0;
    grand_total       = '0;
    foreach (bin_state[i]) bin_state[i] = '0;
    cfg_we_i          = 1'b0;
    cfg_data_i        = 1'b0;
    evt_if.valid      = 1'b0;
    evt_if.command    = CMD_ALLOC;
    evt_if.block_size = '0;
    evt_if.bin_select = '0;
    rec_if.ready      = 1'b0;
    tx_idle_pct       = 32;
    rx_idle_pct       = 64;
    rst_ni            = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // log2 layout: size extremes, free of an unallocated size, out-of-range reads
    queue_event(CMD_READ_TOTAL, 32'h0, 8'd0);
    queue_event(CMD_ALLOC, 32'd0, 8'd0);
    queue_event(CMD_ALLOC, 32'd4, 8'd0);
    queue_event(CMD_ALLOC, 32'd5, 8'd0);
    queue_event(CMD_ALLOC, 32'hFFFF_FFFF, 8'd0);
    queue_event(CMD_ALLOC, 32'h8000_0000, 8'd0);
    queue_event(CMD_ALLOC, 32'h8000_0001, 8'd0);
    queue_event(CMD_FREE, 32'd7, 8'hFF);
    queue_event(CMD_READ_BIN, 32'hFFFF_FFFF, 8'd0);
    queue_event(CMD_READ_BIN, 32'd0, 8'd150);
    queue_event(CMD_READ_BIN, 32'd0, 8'd151);
    queue_event(CMD_READ_BIN, 32'd0, 8'hFF);
    queue_event(CMD_READ_TOTAL, 32'hFFFF_FFFF, 8'hFF);
    queue_event(CMD_ALLOC, 32'hFFFF_FFFF, 8'd0);
    drain();

    // compact layout, counters kept across the switch
    set_mode(1'b1);
    queue_event(CMD_ALLOC, 32'd1, 8'd0);
    queue_event(CMD_ALLOC, 32'd512, 8'd0);
    queue_event(CMD_ALLOC, 32'd513, 8'd0);
    queue_event(CMD_ALLOC, 32'd1024, 8'd0);
    queue_event(CMD_ALLOC, 32'd1025, 8'd0);
    queue_event(CMD_ALLOC, 32'hFFFF_FFFF, 8'd0);
    queue_event(CMD_FREE, 32'd512, 8'd0);
    queue_event(CMD_READ_BIN, 32'd0, 8'd127);
    queue_event(CMD_READ_BIN, 32'd0, 8'd128);
    queue_event(CMD_READ_BIN, 32'd0, 8'd30);
    queue_event(CMD_READ_TOTAL, 32'd0, 8'd0);
    random_phase(150);

    tx_idle_pct = 64;
    rx_idle_pct = 32;
    set_mode(1'b0);
    random_phase(200);
    set_mode(1'b1);
    random_phase(150);

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    set_mode(1'b0);
    random_phase(125);
    set_mode(1'b1);
    random_phase(125);

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
